// File: design/lpi_pkg.sv
// Shared types and constants for the leaky PI lead-lag correction unit.
`default_nettype none

package lpi_pkg;

  // Item field widths and APB bus widths
  localparam int ERR_WIDTH   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int CORR_WIDTH  = 16;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;

  // Register reset values
  localparam logic [15:0] LEAK_FACTOR_RST        = 16'd243;
  localparam logic [4:0]  LEAK_SHIFT_RST         = 5'd8;
  localparam logic [15:0] INTEGRAL_GAIN_RST      = 16'd128;
  localparam logic [4:0]  INTEGRAL_SHIFT_RST     = 5'd9;
  localparam logic [15:0] PROPORTIONAL_GAIN_RST  = 16'd128;
  localparam logic [4:0]  PROPORTIONAL_SHIFT_RST = 5'd9;
  localparam logic [14:0] CORRECTION_LIMIT_RST   = 15'd32767;
  localparam logic [30:0] ACC_LIMIT_RST          = 31'd1497;

  // Register map, word index into the APB space
  typedef enum logic [2:0] {
    REG_LEAK_FACTOR        = 3'd0,
    REG_LEAK_SHIFT         = 3'd1,
    REG_INTEGRAL_GAIN      = 3'd2,
    REG_INTEGRAL_SHIFT     = 3'd3,
    REG_PROPORTIONAL_GAIN  = 3'd4,
    REG_PROPORTIONAL_SHIFT = 3'd5,
    REG_CORRECTION_LIMIT   = 3'd6,
    REG_ACC_LIMIT          = 3'd7
  } reg_idx_t;

  // Register contents seen by the datapath
  typedef struct packed {
    logic [15:0] leak_factor;
    logic [4:0]  leak_shift;
    logic [15:0] integral_gain;
    logic [4:0]  integral_shift;
    logic [15:0] proportional_gain;
    logic [4:0]  proportional_shift;
    logic [14:0] correction_limit;
    logic [30:0] acc_limit;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAK,
    ST_ACC,
    ST_GAIN,
    ST_CORR
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_leak;
    logic do_acc;
    logic do_gain;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/lpi_regs.sv
// APB register file holding gains, shifts and limits.
`default_nettype none

module lpi_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lpi_pkg::ADDR_WIDTH-1:0]    paddr,
  input  wire logic [lpi_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic      [lpi_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                                   pready,
  output lpi_pkg::cfg_t                          cfg
);

  lpi_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = lpi_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leak_factor        <= lpi_pkg::LEAK_FACTOR_RST;
      cfg.leak_shift         <= lpi_pkg::LEAK_SHIFT_RST;
      cfg.integral_gain      <= lpi_pkg::INTEGRAL_GAIN_RST;
      cfg.integral_shift     <= lpi_pkg::INTEGRAL_SHIFT_RST;
      cfg.proportional_gain  <= lpi_pkg::PROPORTIONAL_GAIN_RST;
      cfg.proportional_shift <= lpi_pkg::PROPORTIONAL_SHIFT_RST;
      cfg.correction_limit   <= lpi_pkg::CORRECTION_LIMIT_RST;
      cfg.acc_limit          <= lpi_pkg::ACC_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        lpi_pkg::REG_LEAK_FACTOR:        cfg.leak_factor        <= pwdata[15:0];
        lpi_pkg::REG_LEAK_SHIFT:         cfg.leak_shift         <= pwdata[4:0];
        lpi_pkg::REG_INTEGRAL_GAIN:      cfg.integral_gain      <= pwdata[15:0];
        lpi_pkg::REG_INTEGRAL_SHIFT:     cfg.integral_shift     <= pwdata[4:0];
        lpi_pkg::REG_PROPORTIONAL_GAIN:  cfg.proportional_gain  <= pwdata[15:0];
        lpi_pkg::REG_PROPORTIONAL_SHIFT: cfg.proportional_shift <= pwdata[4:0];
        lpi_pkg::REG_CORRECTION_LIMIT:   cfg.correction_limit   <= pwdata[14:0];
        lpi_pkg::REG_ACC_LIMIT:          cfg.acc_limit          <= pwdata[30:0];
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      lpi_pkg::REG_LEAK_FACTOR:        prdata = {16'd0, cfg.leak_factor};
      lpi_pkg::REG_LEAK_SHIFT:         prdata = {27'd0, cfg.leak_shift};
      lpi_pkg::REG_INTEGRAL_GAIN:      prdata = {16'd0, cfg.integral_gain};
      lpi_pkg::REG_INTEGRAL_SHIFT:     prdata = {27'd0, cfg.integral_shift};
      lpi_pkg::REG_PROPORTIONAL_GAIN:  prdata = {16'd0, cfg.proportional_gain};
      lpi_pkg::REG_PROPORTIONAL_SHIFT: prdata = {27'd0, cfg.proportional_shift};
      lpi_pkg::REG_CORRECTION_LIMIT:   prdata = {17'd0, cfg.correction_limit};
      lpi_pkg::REG_ACC_LIMIT:          prdata = {1'b0, cfg.acc_limit};
    endcase
  end

endmodule

`default_nettype wire

// File: design/lpi_ctrl.sv
// Sequencing state machine and output handshake for the correction unit.
`default_nettype none

module lpi_ctrl (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output lpi_pkg::cmd_t cmd
);

  lpi_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  // Output register may be refilled when empty or being emptied this cycle
  assign out_free = ~out_valid | out_ready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpi_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      lpi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = lpi_pkg::ST_LEAK;
        end
      end
      lpi_pkg::ST_LEAK: begin
        cmd.do_leak = 1'b1;
        state_next  = lpi_pkg::ST_ACC;
      end
      lpi_pkg::ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_next = lpi_pkg::ST_GAIN;
      end
      lpi_pkg::ST_GAIN: begin
        cmd.do_gain = 1'b1;
        state_next  = lpi_pkg::ST_CORR;
      end
      lpi_pkg::ST_CORR: begin
        // once the result register is free, finish this item and take the next one in the same cycle
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = lpi_pkg::ST_LEAK;
          end else begin
            state_next  = lpi_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = lpi_pkg::ST_IDLE;
    endcase
  end

  // Result item valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// File: design/lpi_dp.sv
// Datapath: leaky accumulator, gain multiplies, clamps and output registers.
`default_nettype none

module lpi_dp #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lpi_pkg::cmd_t                          cmd,
  input  wire lpi_pkg::cfg_t                          cfg,
  input  wire logic signed [lpi_pkg::ERR_WIDTH-1:0]   position_error,
  input  wire logic        [lpi_pkg::COUNT_WIDTH-1:0] raw_count,
  output logic signed      [lpi_pkg::CORR_WIDTH-1:0]  correction,
  output logic             [lpi_pkg::COUNT_WIDTH-1:0] corrected_count
);

  // product of a 17-bit signed gain and the accumulator, and one guard bit
  localparam int PW  = ACC_WIDTH + 17;
  localparam int LW  = PW + 1;
  localparam int EW  = lpi_pkg::ERR_WIDTH;
  localparam int PPW = EW + 17;

  localparam logic signed [LW-1:0] WIDTH_MAX =
    {{(LW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};

  // symmetric clamp at working width
  function automatic logic signed [LW-1:0] clamp_sym(
    input logic signed [LW-1:0] x,
    input logic signed [LW-1:0] lim
  );
    logic signed [LW-1:0] r;
    r = x;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [EW-1:0]                   err_q;
  logic        [lpi_pkg::COUNT_WIDTH-1:0] raw_q;
  logic signed [ACC_WIDTH-1:0]            acc;
  logic signed [PW-1:0]                   leak_prod;
  logic signed [PW-1:0]                   int_prod;
  logic signed [PPW-1:0]                  prop_prod;

  logic signed [LW-1:0]        acc_lim_ext;
  logic signed [LW-1:0]        alim;
  logic signed [LW-1:0]        acc_old_c;
  logic signed [ACC_WIDTH-1:0] acc_old_n;
  logic signed [PW-1:0]        leak_sh;
  logic signed [LW-1:0]        acc_sum;
  logic signed [LW-1:0]        acc_new;
  logic signed [PW-1:0]        int_sh;
  logic signed [PPW-1:0]       prop_sh;
  logic signed [LW-1:0]        corr_sum;
  logic signed [LW-1:0]        corr_lim;
  logic signed [LW-1:0]        corr_c;

  // accumulator limit, capped to what the accumulator width can hold
  assign acc_lim_ext = {{(LW - 31){1'b0}}, cfg.acc_limit};
  assign alim        = (acc_lim_ext > WIDTH_MAX) ? WIDTH_MAX : acc_lim_ext;

  // leak step: clamp old accumulator against the current limit
  assign acc_old_c = clamp_sym({{(LW - ACC_WIDTH){acc[ACC_WIDTH-1]}}, acc}, alim);
  assign acc_old_n = acc_old_c[ACC_WIDTH-1:0];

  // accumulate step
  assign leak_sh = leak_prod >>> cfg.leak_shift;
  assign acc_sum = {leak_sh[PW-1], leak_sh} + {{(LW - EW){err_q[EW-1]}}, err_q};
  assign acc_new = clamp_sym(acc_sum, alim);

  // correction step
  assign int_sh   = int_prod >>> cfg.integral_shift;
  assign prop_sh  = prop_prod >>> cfg.proportional_shift;
  assign corr_sum = {int_sh[PW-1], int_sh} + {{(LW - PPW){prop_sh[PPW-1]}}, prop_sh};
  assign corr_lim = {{(LW - 15){1'b0}}, cfg.correction_limit};
  assign corr_c   = clamp_sym(corr_sum, corr_lim);

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.do_acc) begin
      acc <= acc_new[ACC_WIDTH-1:0];
    end
  end

  // item capture and multiplier registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_q <= position_error;
      raw_q <= raw_count;
    end
    if (cmd.do_leak) begin
      leak_prod <= $signed({1'b0, cfg.leak_factor}) * acc_old_n;
    end
    if (cmd.do_gain) begin
      int_prod  <= $signed({1'b0, cfg.integral_gain}) * acc;
      prop_prod <= $signed({1'b0, cfg.proportional_gain}) * err_q;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      correction      <= corr_c[lpi_pkg::CORR_WIDTH-1:0];
      corrected_count <= raw_q + corr_c[lpi_pkg::COUNT_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/leaky_pi_lead_lag_correction_unit.sv
// Leaky PI lead-lag correction unit: top level.
//
// Input channel (in_valid/in_ready) carries position_error and raw_count;
// the result channel (out_valid/out_ready) carries correction and
// corrected_count, one result item for every input item, in order.
// Gains, shifts and limits sit in an APB register file (word addresses
// 0x00..0x1C, pready tied high); the user must write them only while the
// block is idle; the block itself does not enforce this.
//
// Each item passes through four steps of the sequencer: leak multiply,
// accumulate and clamp, gain multiplies, correction sum and clamp. The two
// multiply steps are each followed by a register. A new item is taken
// only when the last one has reached its final step.
// The result register sits between the two channels: the next item is taken
// while the last result waits. If the receiver stalls, the unit holds in its
// final step until the result register frees up, and takes no new item.
// Synchronous reset clears the accumulator, the sequencer and out_valid,
// and loads the register defaults.
`default_nettype none

module leaky_pi_lead_lag_correction_unit #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [lpi_pkg::ERR_WIDTH-1:0]   position_error,
  input  wire logic        [lpi_pkg::COUNT_WIDTH-1:0] raw_count,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed      [lpi_pkg::CORR_WIDTH-1:0]  correction,
  output logic             [lpi_pkg::COUNT_WIDTH-1:0] corrected_count,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic        [lpi_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic        [lpi_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic             [lpi_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                                        pready
);

  lpi_pkg::cfg_t cfg;
  lpi_pkg::cmd_t cmd;

  // configuration registers
  lpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  lpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic
  lpi_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .position_error  (position_error),
    .raw_count       (raw_count),
    .correction      (correction),
    .corrected_count (corrected_count)
  );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the leaky PI lead-lag correction unit.
`timescale 1ns / 1ps

module tb_top;

  // Field types used for random stimulus
  typedef logic signed [lpi_pkg::ERR_WIDTH-1:0] err_t;
  typedef logic        [lpi_pkg::COUNT_WIDTH-1:0] count_t;

  // Expected result of one input item
  typedef struct packed {
    logic signed [lpi_pkg::CORR_WIDTH-1:0]  correction;
    logic        [lpi_pkg::COUNT_WIDTH-1:0] corrected_count;
  } corr_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [lpi_pkg::ERR_WIDTH-1:0]  position_error = '0;
  logic [lpi_pkg::COUNT_WIDTH-1:0]       raw_count = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [lpi_pkg::CORR_WIDTH-1:0] correction;
  logic [lpi_pkg::COUNT_WIDTH-1:0]       corrected_count;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [lpi_pkg::ADDR_WIDTH-1:0]        paddr = '0;
  logic [lpi_pkg::DATA_WIDTH-1:0]        pwdata = '0;
  logic [lpi_pkg::DATA_WIDTH-1:0]        prdata;
  logic                                  pready;

  // Predictor state: register shadow and leaky accumulator
  lpi_pkg::cfg_t gain_regs;
  longint        leaky_acc;
  corr_result_t  pending_corrections[$];
  corr_result_t  oldest;
  int            mismatches = 0;
  int            rx_hold = 0;
  int            rx_stall;
  bit            no_gaps = 1'b0;

  leaky_pi_lead_lag_correction_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .position_error  (position_error),
    .raw_count       (raw_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .correction      (correction),
    .corrected_count (corrected_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  function automatic longint clamp_magnitude(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advance the accumulator by one sample and form the correction
  function automatic corr_result_t step_controller(
    logic signed [lpi_pkg::ERR_WIDTH-1:0] err,
    logic [lpi_pkg::COUNT_WIDTH-1:0] raw);
    longint e, acc, acc_lim, corr;
    corr_result_t res;
    e       = longint'(err);
    acc_lim = longint'(gain_regs.acc_limit);
    acc     = clamp_magnitude(leaky_acc, acc_lim);
    acc     = ((longint'(gain_regs.leak_factor) * acc) >>> gain_regs.leak_shift) + e;
    acc     = clamp_magnitude(acc, acc_lim);
    leaky_acc = acc;
    corr = ((longint'(gain_regs.integral_gain) * acc) >>> gain_regs.integral_shift)
         + ((longint'(gain_regs.proportional_gain) * e) >>> gain_regs.proportional_shift);
    corr = clamp_magnitude(corr, longint'(gain_regs.correction_limit));
    res.correction      = corr[lpi_pkg::CORR_WIDTH-1:0];
    res.corrected_count = raw + corr[lpi_pkg::COUNT_WIDTH-1:0];
    return res;
  endfunction

  // Random register value: often an extreme, otherwise anything in range
  function automatic logic [31:0] pick_value(logic [31:0] mask);
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // APB write: setup cycle, access cycle, then the bus returns to idle
  task automatic write_reg(input lpi_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      lpi_pkg::REG_LEAK_FACTOR:        gain_regs.leak_factor        = value[15:0];
      lpi_pkg::REG_LEAK_SHIFT:         gain_regs.leak_shift         = value[4:0];
      lpi_pkg::REG_INTEGRAL_GAIN:      gain_regs.integral_gain      = value[15:0];
      lpi_pkg::REG_INTEGRAL_SHIFT:     gain_regs.integral_shift     = value[4:0];
      lpi_pkg::REG_PROPORTIONAL_GAIN:  gain_regs.proportional_gain  = value[15:0];
      lpi_pkg::REG_PROPORTIONAL_SHIFT: gain_regs.proportional_shift = value[4:0];
      lpi_pkg::REG_CORRECTION_LIMIT:   gain_regs.correction_limit   = value[14:0];
      lpi_pkg::REG_ACC_LIMIT:          gain_regs.acc_limit          = value[30:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Send one sample item after a random gap; predict on acceptance
  task automatic send_sample(input logic signed [lpi_pkg::ERR_WIDTH-1:0] err,
                             input logic [lpi_pkg::COUNT_WIDTH-1:0] raw);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    position_error <= err;
    raw_count      <= raw;
    do @(posedge clk); while (!in_ready);
    pending_corrections.push_back(step_controller(err, raw));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver: random stall after each accepted result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_ready && out_valid) begin
      rx_stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_hold   <= rx_stall - 1;
      end
    end else if (!out_ready) begin
      if (rx_hold == 0) out_ready <= 1'b1;
      else rx_hold <= rx_hold - 1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_corrections.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: corr %0d count %0d", correction, corrected_count);
        mismatches++;
      end else begin
        oldest = pending_corrections.pop_front();
        if (oldest.correction !== correction || oldest.corrected_count !== corrected_count) begin
          if (mismatches < 10)
            $display("mismatch: expected corr %0d count %0d, got corr %0d count %0d",
                     oldest.correction, oldest.corrected_count, correction, corrected_count);
          mismatches++;
        end
      end
    end
  end

  // Reset defaults, error and count extremes
  task automatic test_reset_defaults();
    send_sample(8'sd127, 16'd0);
    send_sample(8'sd127, 16'hFFFF);
    send_sample(8'h80, 16'd0);
    send_sample(8'h80, 16'd1);
    send_sample(8'sd0, 16'h8000);
    send_sample(-8'sd1, 16'hFFFF);
  endtask

  // Largest gains, no shifts: accumulator and correction saturate, count wraps
  task automatic test_register_extremes();
    wait_idle();
    write_reg(lpi_pkg::REG_LEAK_FACTOR, 32'h0000_FFFF);
    write_reg(lpi_pkg::REG_LEAK_SHIFT, 32'd0);
    write_reg(lpi_pkg::REG_INTEGRAL_GAIN, 32'h0000_FFFF);
    write_reg(lpi_pkg::REG_INTEGRAL_SHIFT, 32'd0);
    write_reg(lpi_pkg::REG_PROPORTIONAL_GAIN, 32'h0000_FFFF);
    write_reg(lpi_pkg::REG_PROPORTIONAL_SHIFT, 32'd0);
    write_reg(lpi_pkg::REG_CORRECTION_LIMIT, 32'h0000_7FFF);
    write_reg(lpi_pkg::REG_ACC_LIMIT, 32'h7FFF_FFFF);
    repeat (3) send_sample(8'sd127, 16'hFFF0);
    repeat (3) send_sample(8'h80, 16'h0005);
  endtask

  // Zero limits force zero; limits of one clip hard
  task automatic test_zero_limits();
    wait_idle();
    write_reg(lpi_pkg::REG_CORRECTION_LIMIT, 32'd0);
    write_reg(lpi_pkg::REG_ACC_LIMIT, 32'd0);
    send_sample(8'sd127, 16'd1234);
    send_sample(8'h80, 16'd4321);
    wait_idle();
    write_reg(lpi_pkg::REG_CORRECTION_LIMIT, 32'd1);
    write_reg(lpi_pkg::REG_ACC_LIMIT, 32'd1);
    send_sample(8'sd127, 16'hFFFF);
    send_sample(8'h80, 16'd0);
  endtask

  // Bits above the register width are dropped
  task automatic test_register_masking();
    wait_idle();
    write_reg(lpi_pkg::REG_LEAK_FACTOR, 32'hFFFF_0000);
    write_reg(lpi_pkg::REG_LEAK_SHIFT, 32'hFFFF_FFFF);
    write_reg(lpi_pkg::REG_INTEGRAL_GAIN, 32'hFFFF_0000);
    write_reg(lpi_pkg::REG_INTEGRAL_SHIFT, 32'hFFFF_FFFF);
    write_reg(lpi_pkg::REG_PROPORTIONAL_GAIN, 32'h0001_FFFF);
    write_reg(lpi_pkg::REG_PROPORTIONAL_SHIFT, 32'hFFFF_FFFF);
    write_reg(lpi_pkg::REG_CORRECTION_LIMIT, 32'hFFFF_FFFF);
    write_reg(lpi_pkg::REG_ACC_LIMIT, 32'hFFFF_FFFF);
    send_sample(8'sd127, 16'd77);
    send_sample(8'h80, 16'd0);
    send_sample(-8'sd1, 16'd0);
  endtask

  // New random settings, upper bus bits filled with noise
  task automatic program_random_settings();
    logic [31:0] mask, val;
    bit          tame;
    tame = 1'($urandom_range(0, 1));
    for (int i = 0; i < 8; i++) begin
      case (lpi_pkg::reg_idx_t'(i)) inside
        lpi_pkg::REG_LEAK_SHIFT, lpi_pkg::REG_INTEGRAL_SHIFT,
        lpi_pkg::REG_PROPORTIONAL_SHIFT: mask = 32'h1F;
        lpi_pkg::REG_CORRECTION_LIMIT:   mask = 32'h7FFF;
        lpi_pkg::REG_ACC_LIMIT:          mask = 32'h7FFF_FFFF;
        default:                         mask = 32'hFFFF;
      endcase
      val = pick_value(mask);
      // tame settings keep the loop away from constant saturation
      if (tame) begin
        case (lpi_pkg::reg_idx_t'(i)) inside
          lpi_pkg::REG_LEAK_FACTOR: val = $urandom_range(0, 300);
          lpi_pkg::REG_LEAK_SHIFT:  val = 32'd8;
          lpi_pkg::REG_INTEGRAL_SHIFT,
          lpi_pkg::REG_PROPORTIONAL_SHIFT: val = $urandom_range(6, 14);
          lpi_pkg::REG_CORRECTION_LIMIT,
          lpi_pkg::REG_ACC_LIMIT:          val = $urandom_range(0, 4000);
          default: ;
        endcase
      end
      write_reg(lpi_pkg::reg_idx_t'(i), val | ($urandom & ~mask));
    end
  endtask

  // Random phases: mix of uniform errors and steady drifts with noise
  task automatic test_random_phases();
    int drift;
    logic signed [lpi_pkg::ERR_WIDTH-1:0] err;
    logic [lpi_pkg::COUNT_WIDTH-1:0] raw;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      program_random_settings();
      no_gaps = (phase % 3 == 2);
      drift   = int'($urandom_range(0, 120)) - 60;
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(0, 1)) err = err_t'($urandom_range(0, 255));
        else err = err_t'(drift + int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 7))
          0:       raw = count_t'($urandom_range(0, 15));
          1:       raw = count_t'(32'hFFFF - $urandom_range(0, 15));
          default: raw = count_t'($urandom_range(0, 65535));
        endcase
        send_sample(err, raw);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    gain_regs = '{leak_factor:        lpi_pkg::LEAK_FACTOR_RST,
                  leak_shift:         lpi_pkg::LEAK_SHIFT_RST,
                  integral_gain:      lpi_pkg::INTEGRAL_GAIN_RST,
                  integral_shift:     lpi_pkg::INTEGRAL_SHIFT_RST,
                  proportional_gain:  lpi_pkg::PROPORTIONAL_GAIN_RST,
                  proportional_shift: lpi_pkg::PROPORTIONAL_SHIFT_RST,
                  correction_limit:   lpi_pkg::CORRECTION_LIMIT_RST,
                  acc_limit:          lpi_pkg::ACC_LIMIT_RST};
    leaky_acc = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_zero_limits();
    test_register_masking();
    test_random_phases();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
design/lpi_pkg.sv
design/lpi_regs.sv
design/lpi_ctrl.sv
design/lpi_dp.sv
design/leaky_pi_lead_lag_correction_unit.sv
verif/tb_top.sv
